FILE: rtl/cci_pkg.sv
// ============================================================================
// cci_pkg: shared types and constants for the circle intersection core
// Field widths, pipeline depths and transaction payload structs.
// ============================================================================
package cci_pkg;

    localparam int COORD_W       = 32;   // signed coordinate width
    localparam int RAD_W         = 31;   // unsigned radius width
    localparam int TOL_W         = 32;   // tolerance register width
    localparam int FRAC_BITS_DEF = 16;   // default fraction bits
    localparam int DD_W          = 64;   // squared distance after range check
    localparam int NUM_W         = 100;  // signed numerator width
    localparam int SQRT_STAGES   = DD_W; // one root bit per stage
    localparam int DIV_QBITS     = COORD_W;
    localparam int DIV_LAT       = DIV_QBITS + 4;
    // front end (7) + root + offset terms (3) + divider + output register
    localparam int PIPE_LAT      = 7 + SQRT_STAGES + 3 + DIV_LAT + 1;

    typedef struct packed {
        logic signed [COORD_W-1:0] first_center_x;
        logic signed [COORD_W-1:0] first_center_y;
        logic        [RAD_W-1:0]   first_radius;
        logic signed [COORD_W-1:0] second_center_x;
        logic signed [COORD_W-1:0] second_center_y;
        logic        [RAD_W-1:0]   second_radius;
    } query_t;

    typedef struct packed {
        logic                      intersects;
        logic signed [COORD_W-1:0] point_a_x;
        logic signed [COORD_W-1:0] point_a_y;
        logic signed [COORD_W-1:0] point_b_x;
        logic signed [COORD_W-1:0] point_b_y;
    } result_t;

endpackage

FILE: rtl/cci_div.sv
// ============================================================================
// cci_div: pipelined rounding divider num / (2 * dd)
// Rounds to nearest, ties away from zero, saturates to the coordinate range.
// One quotient bit per stage.
// ============================================================================
module cci_div
    import cci_pkg::*;
(
    input  logic                clk,
    input  logic [NUM_W-1:0]    num,
    input  logic [DD_W-1:0]     dd,
    output logic [COORD_W-1:0]  coord
);

    localparam int N_W   = NUM_W + 1;
    localparam int DEN_W = DD_W + 1;

    // stage a: sign and magnitude
    logic              a_neg_reg;
    logic [NUM_W-1:0]  a_mag_reg;
    logic [DD_W-1:0]   a_dd_reg;
    // stage b: biased numerator, doubled divisor
    logic              b_neg_reg;
    logic [N_W-1:0]    b_n_reg;
    logic [DEN_W-1:0]  b_den_reg;
    // stage c: overflow check
    logic              c_neg_reg;
    logic              c_ovf_reg;
    logic [N_W-1:0]    c_rem_reg;
    logic [DEN_W-1:0]  c_den_reg;
    // quotient stages
    logic [N_W-1:0]       dv_rem_reg [0:DIV_QBITS-2];
    logic [DIV_QBITS-1:0] dv_q_reg   [0:DIV_QBITS-1];
    logic [DEN_W-1:0]     dv_den_reg [0:DIV_QBITS-1];
    logic                 dv_neg_reg [0:DIV_QBITS-1];
    logic                 dv_ovf_reg [0:DIV_QBITS-1];
    logic [COORD_W-1:0]   coord_reg;

    logic [DIV_QBITS-1:0] q_fin;
    logic                 sat_pos;
    logic                 sat_neg;

    always_ff @(posedge clk)
    begin
        a_neg_reg <= num[NUM_W-1];
        a_mag_reg <= num[NUM_W-1] ? (~num + NUM_W'(1)) : num;
        a_dd_reg  <= dd;

        b_neg_reg <= a_neg_reg;
        b_n_reg   <= N_W'(a_mag_reg) + N_W'(a_dd_reg);
        b_den_reg <= {a_dd_reg, 1'b0};

        c_neg_reg <= b_neg_reg;
        c_ovf_reg <= b_n_reg >= (N_W'(b_den_reg) << DIV_QBITS);
        c_rem_reg <= b_n_reg;
        c_den_reg <= b_den_reg;
    end

    for (genvar gk = 0; gk < DIV_QBITS; gk++)
    begin : g_bit
        localparam int SH = DIV_QBITS - 1 - gk;
        logic [N_W-1:0]       rem_in;
        logic [DIV_QBITS-1:0] q_in;
        logic [DEN_W-1:0]     den_in;
        logic                 neg_in;
        logic                 ovf_in;
        logic [N_W-1:0]       den_sh;
        logic                 take;

        if (gk == 0)
        begin : g_first
            assign rem_in = c_rem_reg;
            assign q_in   = '0;
            assign den_in = c_den_reg;
            assign neg_in = c_neg_reg;
            assign ovf_in = c_ovf_reg;
        end
        else
        begin : g_next
            assign rem_in = dv_rem_reg[gk-1];
            assign q_in   = dv_q_reg[gk-1];
            assign den_in = dv_den_reg[gk-1];
            assign neg_in = dv_neg_reg[gk-1];
            assign ovf_in = dv_ovf_reg[gk-1];
        end

        assign den_sh = N_W'(den_in) << SH;
        assign take   = rem_in >= den_sh;

        always_ff @(posedge clk)
        begin
            dv_q_reg[gk]   <= {q_in[DIV_QBITS-2:0], take};
            dv_den_reg[gk] <= den_in;
            dv_neg_reg[gk] <= neg_in;
            dv_ovf_reg[gk] <= ovf_in;
        end

        if (gk < DIV_QBITS - 1)
        begin : g_rem
            always_ff @(posedge clk)
            begin
                dv_rem_reg[gk] <= take ? (rem_in - den_sh) : rem_in;
            end
        end
    end

    assign q_fin   = dv_q_reg[DIV_QBITS-1];
    assign sat_pos = dv_ovf_reg[DIV_QBITS-1] || q_fin[DIV_QBITS-1];
    assign sat_neg = dv_ovf_reg[DIV_QBITS-1]
                  || (q_fin[DIV_QBITS-1] && (|q_fin[DIV_QBITS-2:0]));

    always_ff @(posedge clk)
    begin
        if (!dv_neg_reg[DIV_QBITS-1])
        begin
            coord_reg <= sat_pos ? {1'b0, {(COORD_W-1){1'b1}}} : COORD_W'(q_fin);
        end
        else
        begin
            coord_reg <= sat_neg ? {1'b1, {(COORD_W-1){1'b0}}}
                                 : COORD_W'(~q_fin + DIV_QBITS'(1));
        end
    end

    assign coord = coord_reg;

endmodule

FILE: rtl/circle_circle_intersection_core.sv
// ============================================================================
// circle_circle_intersection_core: fixed-point circle/circle intersection
// Returns both meeting points of two circles and a flag, fully pipelined.
// ============================================================================
//
//  channel   | handshake                | payload           | notes
//  ----------+--------------------------+-------------------+-----------------
//  query     | start & !busy            | query_t           | one per cycle
//  result    | done (one-cycle strobe)  | result_t          | cannot be held
//  config    | cfg_valid & cfg_ready    | cfg_data (32 bit) | zero_tolerance
//
//  A new query may be accepted every cycle once busy is low. Depth is set by the
//  square root (one root bit per stage, 64 stages) and the divider (one quotient
//  bit per stage). rst_n clears the valid chain and the tolerance; busy stays
//  high until the first clock after reset is released. Nothing stalls: the
//  pipeline moves every cycle.
//
module circle_circle_intersection_core
    import cci_pkg::*;
#(
    parameter int FRACTION_BITS = FRAC_BITS_DEF
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  query_t            query,
    output logic              done,
    output result_t           result,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [TOL_W-1:0]  cfg_data
);

    localparam int AB_W   = COORD_W + 1;       // center difference / sum
    localparam int RSQ_W  = 2 * RAD_W;         // radius squares
    localparam int QH     = RSQ_W / 2;         // split point of |Q|
    localparam int SQ_W   = 2 * COORD_W;       // squared coordinate difference
    localparam int D2_W   = SQ_W + 1;
    localparam int TOLS_W = TOL_W + FRACTION_BITS;
    localparam int CMP_W  = (TOLS_W > D2_W) ? TOLS_W : D2_W;
    localparam int HW     = DD_W / 2;          // 32-bit partial product halves
    localparam int BM_W   = AB_W + DD_W;       // |sum| * dd
    localparam int TM_W   = AB_W + RSQ_W;      // |diff| * |Q|
    localparam int P_W    = 2 * DD_W;          // radicand
    localparam int REM_W  = DD_W + 2;

    typedef struct packed {
        logic             ok;
        logic [DD_W-1:0]  dd;
        logic [NUM_W-1:0] bx;
        logic [NUM_W-1:0] by;
        logic [AB_W-1:0]  adx;
        logic [AB_W-1:0]  ady;
        logic             dxn;
        logic             dyn;
    } side_t;

    function automatic logic [NUM_W-1:0] cneg(input logic [NUM_W-1:0] m, input logic n);
        cneg = n ? (~m + NUM_W'(1)) : m;
    endfunction

    function automatic logic [AB_W-1:0] mag(input logic [AB_W-1:0] v);
        mag = v[AB_W-1] ? (~v + AB_W'(1)) : v;
    endfunction

    // ------------------------------------------------------------------------
    // control
    // ------------------------------------------------------------------------
    logic                busy_reg;
    logic [TOL_W-1:0]    tol_reg;
    logic [PIPE_LAT-1:0] vld_reg;
    logic [PIPE_LAT-1:0] vld_next;
    logic                accept;
    logic [TOLS_W-1:0]   tol_scaled;

    assign accept     = start && !busy_reg;
    assign busy       = busy_reg;
    assign cfg_ready  = !busy_reg;
    assign vld_next   = {vld_reg[PIPE_LAT-2:0], accept};
    assign tol_scaled = TOLS_W'(tol_reg) << FRACTION_BITS;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b1;
            tol_reg  <= '0;
            vld_reg  <= '0;
        end
        else
        begin
            busy_reg <= 1'b0;
            vld_reg  <= vld_next;
            if (cfg_valid && cfg_ready)
            begin
                tol_reg <= cfg_data;
            end
        end
    end

    // ------------------------------------------------------------------------
    // front end: differences, squares, range check, wide products
    // ------------------------------------------------------------------------
    logic [AB_W-1:0]   p1_dx_reg, p1_dy_reg, p1_sx_reg, p1_sy_reg;
    logic [RAD_W-1:0]  p1_r1_reg, p1_r2_reg, p1_rdif_reg;
    logic [RAD_W:0]    p1_rsum_reg;

    logic [AB_W-1:0]   p2_adx_reg, p2_ady_reg, p2_asx_reg, p2_asy_reg;
    logic              p2_dxn_reg, p2_dyn_reg, p2_sxn_reg, p2_syn_reg;
    logic [RSQ_W-1:0]  p2_r1sq_reg, p2_r2sq_reg, p2_dsq_reg;
    logic [DD_W-1:0]   p2_ssq_reg;

    logic [SQ_W-1:0]   p3_adx2_reg, p3_ady2_reg;
    logic [RSQ_W-1:0]  p3_qm_reg, p3_dsq_reg;
    logic              p3_qn_reg;
    logic [DD_W-1:0]   p3_ssq_reg;
    logic [AB_W-1:0]   p3_adx_reg, p3_ady_reg, p3_asx_reg, p3_asy_reg;
    logic              p3_dxn_reg, p3_dyn_reg, p3_sxn_reg, p3_syn_reg;

    logic [D2_W-1:0]   p4_d2_reg;
    logic [RSQ_W-1:0]  p4_qm_reg, p4_dsq_reg;
    logic              p4_qn_reg;
    logic [DD_W-1:0]   p4_ssq_reg;
    logic [AB_W-1:0]   p4_adx_reg, p4_ady_reg, p4_asx_reg, p4_asy_reg;
    logic              p4_dxn_reg, p4_dyn_reg, p4_sxn_reg, p4_syn_reg;

    logic              p5_ok_reg;
    logic [DD_W-1:0]   p5_dd_reg, p5_a_reg, p5_b_reg;
    logic [RSQ_W-1:0]  p5_qm_reg;
    logic              p5_qn_reg;
    logic [AB_W-1:0]   p5_adx_reg, p5_ady_reg, p5_asx_reg, p5_asy_reg;
    logic              p5_dxn_reg, p5_dyn_reg, p5_sxn_reg, p5_syn_reg;

    logic [DD_W-1:0]   p6_pp00_reg, p6_pp01_reg, p6_pp10_reg, p6_pp11_reg;
    logic [AB_W+HW-1:0] p6_bxl_reg, p6_bxh_reg, p6_byl_reg, p6_byh_reg;
    logic [AB_W+QH-1:0] p6_txl_reg, p6_txh_reg, p6_tyl_reg, p6_tyh_reg;
    logic              p6_sxn_reg, p6_syn_reg, p6_txn_reg, p6_tyn_reg;
    logic              p6_ok_reg;
    logic [DD_W-1:0]   p6_dd_reg;
    logic [AB_W-1:0]   p6_adx_reg, p6_ady_reg;
    logic              p6_dxn_reg, p6_dyn_reg;

    logic [P_W-1:0]    p7_prod_reg;
    logic [BM_W-1:0]   p7_bxm_reg, p7_bym_reg;
    logic [TM_W-1:0]   p7_txm_reg, p7_tym_reg;
    logic              p7_sxn_reg, p7_syn_reg, p7_txn_reg, p7_tyn_reg;
    logic              p7_ok_reg;
    logic [DD_W-1:0]   p7_dd_reg;
    logic [AB_W-1:0]   p7_adx_reg, p7_ady_reg;
    logic              p7_dxn_reg, p7_dyn_reg;

    always_ff @(posedge clk)
    begin
        // stage 1: sign-extended sums and differences
        p1_dx_reg   <= {query.second_center_x[COORD_W-1], query.second_center_x}
                     - {query.first_center_x[COORD_W-1], query.first_center_x};
        p1_dy_reg   <= {query.second_center_y[COORD_W-1], query.second_center_y}
                     - {query.first_center_y[COORD_W-1], query.first_center_y};
        p1_sx_reg   <= {query.second_center_x[COORD_W-1], query.second_center_x}
                     + {query.first_center_x[COORD_W-1], query.first_center_x};
        p1_sy_reg   <= {query.second_center_y[COORD_W-1], query.second_center_y}
                     + {query.first_center_y[COORD_W-1], query.first_center_y};
        p1_r1_reg   <= query.first_radius;
        p1_r2_reg   <= query.second_radius;
        p1_rsum_reg <= {1'b0, query.first_radius} + {1'b0, query.second_radius};
        p1_rdif_reg <= (query.first_radius > query.second_radius)
                     ? (query.first_radius - query.second_radius)
                     : (query.second_radius - query.first_radius);

        // stage 2: magnitudes, radius squares
        p2_adx_reg  <= mag(p1_dx_reg);
        p2_ady_reg  <= mag(p1_dy_reg);
        p2_asx_reg  <= mag(p1_sx_reg);
        p2_asy_reg  <= mag(p1_sy_reg);
        p2_dxn_reg  <= p1_dx_reg[AB_W-1];
        p2_dyn_reg  <= p1_dy_reg[AB_W-1];
        p2_sxn_reg  <= p1_sx_reg[AB_W-1];
        p2_syn_reg  <= p1_sy_reg[AB_W-1];
        p2_r1sq_reg <= p1_r1_reg * p1_r1_reg;
        p2_r2sq_reg <= p1_r2_reg * p1_r2_reg;
        p2_ssq_reg  <= p1_rsum_reg * p1_rsum_reg;
        p2_dsq_reg  <= p1_rdif_reg * p1_rdif_reg;

        // stage 3: coordinate squares, Q = r1^2 - r2^2 as sign/magnitude
        p3_adx2_reg <= p2_adx_reg * p2_adx_reg;
        p3_ady2_reg <= p2_ady_reg * p2_ady_reg;
        p3_qn_reg   <= p2_r2sq_reg > p2_r1sq_reg;
        p3_qm_reg   <= (p2_r2sq_reg > p2_r1sq_reg) ? (p2_r2sq_reg - p2_r1sq_reg)
                                                   : (p2_r1sq_reg - p2_r2sq_reg);
        p3_ssq_reg  <= p2_ssq_reg;
        p3_dsq_reg  <= p2_dsq_reg;
        p3_adx_reg  <= p2_adx_reg;
        p3_ady_reg  <= p2_ady_reg;
        p3_asx_reg  <= p2_asx_reg;
        p3_asy_reg  <= p2_asy_reg;
        p3_dxn_reg  <= p2_dxn_reg;
        p3_dyn_reg  <= p2_dyn_reg;
        p3_sxn_reg  <= p2_sxn_reg;
        p3_syn_reg  <= p2_syn_reg;

        // stage 4: squared center distance
        p4_d2_reg   <= D2_W'(p3_adx2_reg) + D2_W'(p3_ady2_reg);
        p4_qm_reg   <= p3_qm_reg;
        p4_qn_reg   <= p3_qn_reg;
        p4_ssq_reg  <= p3_ssq_reg;
        p4_dsq_reg  <= p3_dsq_reg;
        p4_adx_reg  <= p3_adx_reg;
        p4_ady_reg  <= p3_ady_reg;
        p4_asx_reg  <= p3_asx_reg;
        p4_asy_reg  <= p3_asy_reg;
        p4_dxn_reg  <= p3_dxn_reg;
        p4_dyn_reg  <= p3_dyn_reg;
        p4_sxn_reg  <= p3_sxn_reg;
        p4_syn_reg  <= p3_syn_reg;

        // stage 5: intersection test; radicand factors (S - d2), (d2 - Dr)
        p5_ok_reg   <= (CMP_W'(p4_d2_reg) > CMP_W'(p4_dsq_reg))
                    && (CMP_W'(p4_d2_reg) <= CMP_W'(p4_ssq_reg))
                    && (CMP_W'(p4_d2_reg) > CMP_W'(tol_scaled));
        p5_dd_reg   <= p4_d2_reg[DD_W-1:0];
        p5_a_reg    <= p4_ssq_reg - p4_d2_reg[DD_W-1:0];
        p5_b_reg    <= p4_d2_reg[DD_W-1:0] - DD_W'(p4_dsq_reg);
        p5_qm_reg   <= p4_qm_reg;
        p5_qn_reg   <= p4_qn_reg;
        p5_adx_reg  <= p4_adx_reg;
        p5_ady_reg  <= p4_ady_reg;
        p5_asx_reg  <= p4_asx_reg;
        p5_asy_reg  <= p4_asy_reg;
        p5_dxn_reg  <= p4_dxn_reg;
        p5_dyn_reg  <= p4_dyn_reg;
        p5_sxn_reg  <= p4_sxn_reg;
        p5_syn_reg  <= p4_syn_reg;

        // stage 6: 32-bit partial products
        p6_pp00_reg <= p5_a_reg[HW-1:0]    * p5_b_reg[HW-1:0];
        p6_pp01_reg <= p5_a_reg[HW-1:0]    * p5_b_reg[DD_W-1:HW];
        p6_pp10_reg <= p5_a_reg[DD_W-1:HW] * p5_b_reg[HW-1:0];
        p6_pp11_reg <= p5_a_reg[DD_W-1:HW] * p5_b_reg[DD_W-1:HW];
        p6_bxl_reg  <= p5_asx_reg * p5_dd_reg[HW-1:0];
        p6_bxh_reg  <= p5_asx_reg * p5_dd_reg[DD_W-1:HW];
        p6_byl_reg  <= p5_asy_reg * p5_dd_reg[HW-1:0];
        p6_byh_reg  <= p5_asy_reg * p5_dd_reg[DD_W-1:HW];
        p6_txl_reg  <= p5_adx_reg * p5_qm_reg[QH-1:0];
        p6_txh_reg  <= p5_adx_reg * p5_qm_reg[RSQ_W-1:QH];
        p6_tyl_reg  <= p5_ady_reg * p5_qm_reg[QH-1:0];
        p6_tyh_reg  <= p5_ady_reg * p5_qm_reg[RSQ_W-1:QH];
        p6_sxn_reg  <= p5_sxn_reg;
        p6_syn_reg  <= p5_syn_reg;
        p6_txn_reg  <= p5_dxn_reg ^ p5_qn_reg;
        p6_tyn_reg  <= p5_dyn_reg ^ p5_qn_reg;
        p6_ok_reg   <= p5_ok_reg;
        p6_dd_reg   <= p5_dd_reg;
        p6_adx_reg  <= p5_adx_reg;
        p6_ady_reg  <= p5_ady_reg;
        p6_dxn_reg  <= p5_dxn_reg;
        p6_dyn_reg  <= p5_dyn_reg;

        // stage 7: assemble radicand and base-term magnitudes
        p7_prod_reg <= P_W'(p6_pp00_reg) + (P_W'(p6_pp01_reg) << HW)
                     + (P_W'(p6_pp10_reg) << HW) + (P_W'(p6_pp11_reg) << DD_W);
        p7_bxm_reg  <= BM_W'(p6_bxl_reg) + (BM_W'(p6_bxh_reg) << HW);
        p7_bym_reg  <= BM_W'(p6_byl_reg) + (BM_W'(p6_byh_reg) << HW);
        p7_txm_reg  <= TM_W'(p6_txl_reg) + (TM_W'(p6_txh_reg) << QH);
        p7_tym_reg  <= TM_W'(p6_tyl_reg) + (TM_W'(p6_tyh_reg) << QH);
        p7_sxn_reg  <= p6_sxn_reg;
        p7_syn_reg  <= p6_syn_reg;
        p7_txn_reg  <= p6_txn_reg;
        p7_tyn_reg  <= p6_tyn_reg;
        p7_ok_reg   <= p6_ok_reg;
        p7_dd_reg   <= p6_dd_reg;
        p7_adx_reg  <= p6_adx_reg;
        p7_ady_reg  <= p6_ady_reg;
        p7_dxn_reg  <= p6_dxn_reg;
        p7_dyn_reg  <= p6_dyn_reg;
    end

    // ------------------------------------------------------------------------
    // side channel: base terms (x1+x2)*dd + dx*Q ride alongside the root
    // ------------------------------------------------------------------------
    side_t side_reg [0:SQRT_STAGES-1];

    always_ff @(posedge clk)
    begin
        side_reg[0].ok  <= p7_ok_reg;
        side_reg[0].dd  <= p7_dd_reg;
        side_reg[0].bx  <= cneg(NUM_W'(p7_bxm_reg), p7_sxn_reg)
                         + cneg(NUM_W'(p7_txm_reg), p7_txn_reg);
        side_reg[0].by  <= cneg(NUM_W'(p7_bym_reg), p7_syn_reg)
                         + cneg(NUM_W'(p7_tym_reg), p7_tyn_reg);
        side_reg[0].adx <= p7_adx_reg;
        side_reg[0].ady <= p7_ady_reg;
        side_reg[0].dxn <= p7_dxn_reg;
        side_reg[0].dyn <= p7_dyn_reg;
    end

    for (genvar gs = 1; gs < SQRT_STAGES; gs++)
    begin : g_side
        always_ff @(posedge clk)
        begin
            side_reg[gs] <= side_reg[gs-1];
        end
    end

    // ------------------------------------------------------------------------
    // square root: digit recurrence, one root bit per stage
    // ------------------------------------------------------------------------
    logic [REM_W-1:0] sq_rem_reg  [0:SQRT_STAGES-2];
    logic [P_W-1:0]   sq_rad_reg  [0:SQRT_STAGES-2];
    logic [DD_W-1:0]  sq_root_reg [0:SQRT_STAGES-1];

    for (genvar gi = 0; gi < SQRT_STAGES; gi++)
    begin : g_sqrt
        logic [REM_W-1:0] rem_in;
        logic [DD_W-1:0]  root_in;
        logic [P_W-1:0]   rad_in;
        logic [REM_W+1:0] cand;
        logic [REM_W+1:0] test;
        logic             fit;

        if (gi == 0)
        begin : g_first
            assign rem_in  = '0;
            assign root_in = '0;
            assign rad_in  = p7_prod_reg;
        end
        else
        begin : g_next
            assign rem_in  = sq_rem_reg[gi-1];
            assign root_in = sq_root_reg[gi-1];
            assign rad_in  = sq_rad_reg[gi-1];
        end

        // bring down the next two radicand bits, try root*4 + 1
        assign cand = {rem_in, rad_in[P_W-1 -: 2]};
        assign test = (REM_W+2)'({root_in, 2'b01});
        assign fit  = cand >= test;

        always_ff @(posedge clk)
        begin
            sq_root_reg[gi] <= {root_in[DD_W-2:0], fit};
        end

        if (gi < SQRT_STAGES - 1)
        begin : g_carry
            always_ff @(posedge clk)
            begin
                sq_rad_reg[gi] <= rad_in << 2;
                sq_rem_reg[gi] <= fit ? REM_W'(cand - test) : REM_W'(cand);
            end
        end
    end

    // ------------------------------------------------------------------------
    // offset terms dy*s, dx*s and the four numerators
    // ------------------------------------------------------------------------
    logic [AB_W+HW-1:0] p72_oxl_reg, p72_oxh_reg, p72_oyl_reg, p72_oyh_reg;
    side_t              p72_side_reg;
    logic [BM_W-1:0]    p73_oxm_reg, p73_oym_reg;
    side_t              p73_side_reg;
    logic [NUM_W-1:0]   p74_nax_reg, p74_nay_reg, p74_nbx_reg, p74_nby_reg;
    logic [DD_W-1:0]    p74_dd_reg;
    logic               p74_ok_reg;
    logic [DIV_LAT-1:0] ok_pipe_reg;
    logic [DD_W-1:0]    root;

    assign root = sq_root_reg[SQRT_STAGES-1];

    always_ff @(posedge clk)
    begin
        p72_oxl_reg  <= side_reg[SQRT_STAGES-1].ady * root[HW-1:0];
        p72_oxh_reg  <= side_reg[SQRT_STAGES-1].ady * root[DD_W-1:HW];
        p72_oyl_reg  <= side_reg[SQRT_STAGES-1].adx * root[HW-1:0];
        p72_oyh_reg  <= side_reg[SQRT_STAGES-1].adx * root[DD_W-1:HW];
        p72_side_reg <= side_reg[SQRT_STAGES-1];

        p73_oxm_reg  <= BM_W'(p72_oxl_reg) + (BM_W'(p72_oxh_reg) << HW);
        p73_oym_reg  <= BM_W'(p72_oyl_reg) + (BM_W'(p72_oyh_reg) << HW);
        p73_side_reg <= p72_side_reg;

        // a = base + (dy*s, -dx*s), b = base - (dy*s, -dx*s)
        p74_nax_reg  <= p73_side_reg.bx + cneg(NUM_W'(p73_oxm_reg), p73_side_reg.dyn);
        p74_nbx_reg  <= p73_side_reg.bx + cneg(NUM_W'(p73_oxm_reg), !p73_side_reg.dyn);
        p74_nay_reg  <= p73_side_reg.by + cneg(NUM_W'(p73_oym_reg), !p73_side_reg.dxn);
        p74_nby_reg  <= p73_side_reg.by + cneg(NUM_W'(p73_oym_reg), p73_side_reg.dxn);
        p74_dd_reg   <= p73_side_reg.dd;
        p74_ok_reg   <= p73_side_reg.ok;

        ok_pipe_reg  <= {ok_pipe_reg[DIV_LAT-2:0], p74_ok_reg};
    end

    // ------------------------------------------------------------------------
    // dividers and result register
    // ------------------------------------------------------------------------
    logic [COORD_W-1:0] ax, ay, bx_c, by_c;
    result_t            result_reg;

    cci_div u_div_ax (.clk(clk), .num(p74_nax_reg), .dd(p74_dd_reg), .coord(ax));
    cci_div u_div_ay (.clk(clk), .num(p74_nay_reg), .dd(p74_dd_reg), .coord(ay));
    cci_div u_div_bx (.clk(clk), .num(p74_nbx_reg), .dd(p74_dd_reg), .coord(bx_c));
    cci_div u_div_by (.clk(clk), .num(p74_nby_reg), .dd(p74_dd_reg), .coord(by_c));

    always_ff @(posedge clk)
    begin
        // circles that do not meet report zeros
        result_reg.intersects <= ok_pipe_reg[DIV_LAT-1];
        result_reg.point_a_x  <= ok_pipe_reg[DIV_LAT-1] ? ax   : '0;
        result_reg.point_a_y  <= ok_pipe_reg[DIV_LAT-1] ? ay   : '0;
        result_reg.point_b_x  <= ok_pipe_reg[DIV_LAT-1] ? bx_c : '0;
        result_reg.point_b_y  <= ok_pipe_reg[DIV_LAT-1] ? by_c : '0;
    end

    assign result = result_reg;
    assign done   = vld_reg[PIPE_LAT-1];

endmodule

FILE: rtl/cci_chk.sv
// ============================================================================
// cci_chk: port-level checks for the circle intersection core
// Fixed latency and zeroed points on a miss.
// ============================================================================
module cci_chk
    import cci_pkg::*;
(
    input logic    clk,
    input logic    rst_n,
    input logic    start,
    input logic    busy,
    input logic    done,
    input result_t result
);

    a_lat_fwd: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##PIPE_LAT done)
        else $error("accepted transaction gave no result after fixed latency");

    a_lat_back: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start && !busy, PIPE_LAT))
        else $error("result without a matching accepted transaction");

    a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && !result.intersects) |->
            (result.point_a_x == '0) && (result.point_a_y == '0)
         && (result.point_b_x == '0) && (result.point_b_y == '0))
        else $error("non-intersecting result carries nonzero points");

endmodule

bind circle_circle_intersection_core cci_chk u_cci_chk (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .busy   (busy),
    .done   (done),
    .result (result)
);
